/* rtl/core/teq_pkg.sv */
// Shared widths, register indexes, reset values and control types of the three-band equalizer.
package teq_pkg;

  localparam int CHANNELS_DEF = 8;

  localparam int CH_W       = 3;
  localparam int SMP_W      = 24;
  localparam int COEF_W     = 17;
  localparam int GAIN_W     = 20;
  localparam int POLE_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam int SEC_IDX_W  = 3;

  localparam logic [COEF_W-1:0] LOW_COEF_RST  = 17'd6861;
  localparam logic [COEF_W-1:0] HIGH_COEF_RST = 17'd42599;
  localparam logic [GAIN_W-1:0] GAIN_RST      = 20'd65536;

  localparam logic [CFG_IDX_W-1:0] REG_LOW_COEF  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_COEF = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_GAIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MID_GAIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_GAIN = 3'd4;

  // Section index of the last pole of the low cascade and of the high cascade.
  localparam logic [SEC_IDX_W-1:0] LOW_LAST_SEC  = 3'd3;
  localparam logic [SEC_IDX_W-1:0] HIGH_LAST_SEC = 3'd7;

  typedef enum logic [1:0] {
    GAIN_LOW,
    GAIN_MID,
    GAIN_HIGH
  } teq_gain_e;

  typedef struct packed {
    logic                 load;
    logic                 pole_rd;
    logic                 hist_wr;
    logic                 mul_pole;
    logic                 upd_pole;
    logic                 mul_gain;
    logic                 acc_first;
    logic                 acc_add;
    logic                 out_load;
    logic [SEC_IDX_W-1:0] rd_idx;
    logic [SEC_IDX_W-1:0] op_idx;
    teq_gain_e            gsel;
  } teq_cmd_t;

  typedef struct packed {
    logic bypass;
    logic out_free;
  } teq_stat_t;

endpackage

/* rtl/core/teq_in_if.sv */
// Input channel of the equalizer: one sample word with its channel number.
interface teq_in_if;
  logic                            valid;
  logic                            ready;
  logic [teq_pkg::CH_W-1:0]        channel;
  logic signed [teq_pkg::SMP_W-1:0] sample_in;

  modport source (output valid, output channel, output sample_in, input ready);
  modport sink (input valid, input channel, input sample_in, output ready);
endinterface

/* rtl/core/teq_out_if.sv */
// Output channel of the equalizer: one equalized sample word with its channel number.
interface teq_out_if;
  logic                            valid;
  logic                            ready;
  logic [teq_pkg::CH_W-1:0]        channel_out;
  logic signed [teq_pkg::SMP_W-1:0] sample_out;

  modport source (output valid, output channel_out, output sample_out, input ready);
  modport sink (input valid, input channel_out, input sample_out, output ready);
endinterface

/* rtl/core/teq_ctrl.sv */
// Sequencer of the equalizer: steps the shared multiplier through poles, gains and output.
module teq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  teq_pkg::teq_stat_t stat_i,
  output teq_pkg::teq_cmd_t  cmd_o
);
  import teq_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;
  localparam logic [3:0] S_MUL  = 4'd2;
  localparam logic [3:0] S_UPD  = 4'd3;
  localparam logic [3:0] S_G0   = 4'd4;
  localparam logic [3:0] S_G1   = 4'd5;
  localparam logic [3:0] S_G2   = 4'd6;
  localparam logic [3:0] S_G3   = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  logic [3:0]           state_q, state_d;
  logic [SEC_IDX_W-1:0] idx_q, idx_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.gsel = GAIN_LOW;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_RD;
        end
      end
      S_RD: begin
        if (stat_i.bypass) begin
          state_d = S_OUT;
        end else begin
          cmd_o.pole_rd = 1'b1;
          cmd_o.rd_idx  = '0;
          cmd_o.hist_wr = 1'b1;
          idx_d         = '0;
          state_d       = S_MUL;
        end
      end
      S_MUL: begin
        // The next pole is fetched while this one is multiplied.
        cmd_o.mul_pole = 1'b1;
        cmd_o.op_idx   = idx_q;
        if (idx_q != HIGH_LAST_SEC) begin
          cmd_o.pole_rd = 1'b1;
          cmd_o.rd_idx  = idx_q + 3'd1;
        end
        state_d = S_UPD;
      end
      S_UPD: begin
        cmd_o.upd_pole = 1'b1;
        cmd_o.op_idx   = idx_q;
        if (idx_q == HIGH_LAST_SEC) begin
          state_d = S_G0;
        end else begin
          idx_d   = idx_q + 3'd1;
          state_d = S_MUL;
        end
      end
      S_G0: begin
        cmd_o.mul_gain = 1'b1;
        cmd_o.gsel     = GAIN_LOW;
        state_d        = S_G1;
      end
      S_G1: begin
        cmd_o.acc_first = 1'b1;
        cmd_o.mul_gain  = 1'b1;
        cmd_o.gsel      = GAIN_MID;
        state_d         = S_G2;
      end
      S_G2: begin
        cmd_o.acc_add  = 1'b1;
        cmd_o.mul_gain = 1'b1;
        cmd_o.gsel     = GAIN_HIGH;
        state_d        = S_G3;
      end
      S_G3: begin
        cmd_o.acc_add = 1'b1;
        state_d       = S_OUT;
      end
      S_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  a_mul_upd_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.mul_pole && cmd_o.upd_pole))
    else $error("pole multiply and pole update issued together");

  a_gain_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.upd_pole && cmd_o.op_idx == HIGH_LAST_SEC) |=>
      (cmd_o.mul_gain && cmd_o.gsel == GAIN_LOW))
    else $error("gain phase did not follow the last pole");

  a_busy_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> !in_ready_o)
    else $error("ready while a word is in work");

  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> stat_i.out_free)
    else $error("output register overwritten");

endmodule

/* rtl/core/teq_dpath.sv */
// Datapath of the equalizer: state memories, shared multiplier, accumulator and output register.
module teq_dpath #(
  parameter int CHANNELS = teq_pkg::CHANNELS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  teq_pkg::teq_cmd_t                   cmd_i,
  output teq_pkg::teq_stat_t                  stat_o,
  input  logic [teq_pkg::CH_W-1:0]            in_channel_i,
  input  logic signed [teq_pkg::SMP_W-1:0]    in_sample_i,
  input  logic                                cfg_we_i,
  input  logic [teq_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [teq_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [teq_pkg::CH_W-1:0]            out_channel_o,
  output logic signed [teq_pkg::SMP_W-1:0]    out_sample_o
);
  import teq_pkg::*;

  localparam int CH_AW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int POLE_AW    = CH_AW + SEC_IDX_W;
  localparam int POLE_DEPTH = CHANNELS * 8;
  localparam int HIST_AW    = CH_AW + 2;
  localparam int HIST_DEPTH = CHANNELS * 4;
  localparam logic [1:0] HIST_PTR_LAST = 2'd2;

  // Configuration registers.
  logic [COEF_W-1:0] low_coef_q, high_coef_q;
  logic [GAIN_W-1:0] low_gain_q, mid_gain_q, high_gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_coef_q  <= LOW_COEF_RST;
      high_coef_q <= HIGH_COEF_RST;
      low_gain_q  <= GAIN_RST;
      mid_gain_q  <= GAIN_RST;
      high_gain_q <= GAIN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LOW_COEF:  low_coef_q  <= cfg_data_i[COEF_W-1:0];
        REG_HIGH_COEF: high_coef_q <= cfg_data_i[COEF_W-1:0];
        REG_LOW_GAIN:  low_gain_q  <= cfg_data_i;
        REG_MID_GAIN:  mid_gain_q  <= cfg_data_i;
        REG_HIGH_GAIN: high_gain_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Captured word.
  logic [CH_W-1:0]         ch_q;
  logic [CH_AW-1:0]        ch_idx_q, ch_in_idx;
  logic signed [SMP_W-1:0] smp_q;
  logic                    bypass_q;
  logic [HIST_AW-1:0]      hist_addr_q, hist_addr_in;
  logic [1:0]              ptr_q [CHANNELS];

  assign ch_in_idx    = CH_AW'(in_channel_i);
  assign hist_addr_in = {ch_in_idx, ptr_q[ch_in_idx]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ch_q        <= in_channel_i;
      ch_idx_q    <= ch_in_idx;
      smp_q       <= in_sample_i;
      hist_addr_q <= hist_addr_in;
    end
  end

  // Input history: a three-entry ring per channel, the oldest entry sits at the pointer.
  logic signed [SMP_W-1:0] hist_mem [HIST_DEPTH];
  logic [HIST_DEPTH-1:0]   hist_vld_q;
  logic signed [SMP_W-1:0] hist_rd_q, hist_eff;
  logic                    hist_rv_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.hist_wr) hist_mem[hist_addr_q] <= smp_q;
    if (cmd_i.load)    hist_rd_q <= hist_mem[hist_addr_in];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bypass_q   <= 1'b0;
      hist_vld_q <= '0;
      hist_rv_q  <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) ptr_q[c] <= '0;
    end else begin
      if (cmd_i.load) begin
        bypass_q  <= (32'(in_channel_i) >= CHANNELS);
        hist_rv_q <= hist_vld_q[hist_addr_in];
      end
      if (cmd_i.hist_wr) begin
        hist_vld_q[hist_addr_q] <= 1'b1;
        ptr_q[ch_idx_q] <= (ptr_q[ch_idx_q] == HIST_PTR_LAST) ? 2'd0 : ptr_q[ch_idx_q] + 2'd1;
      end
    end
  end

  assign hist_eff = hist_rv_q ? hist_rd_q : '0;

  // Pole memory, addressed by channel and section (low cascade first).
  logic signed [POLE_W-1:0] pole_mem [POLE_DEPTH];
  logic [POLE_DEPTH-1:0]    pole_vld_q;
  logic signed [POLE_W-1:0] pole_rdata_q, p_cur, p_q, new_pole;
  logic                     pole_rvld_q;
  logic [POLE_AW-1:0]       pole_raddr, pole_waddr;

  assign pole_raddr = {ch_idx_q, cmd_i.rd_idx};
  assign pole_waddr = {ch_idx_q, cmd_i.op_idx};

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd_pole) pole_mem[pole_waddr] <= new_pole;
    if (cmd_i.pole_rd)  pole_rdata_q <= pole_mem[pole_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pole_vld_q  <= '0;
      pole_rvld_q <= 1'b0;
    end else begin
      if (cmd_i.upd_pole) pole_vld_q[pole_waddr] <= 1'b1;
      if (cmd_i.pole_rd)  pole_rvld_q <= pole_vld_q[pole_raddr];
    end
  end

  assign p_cur = pole_rvld_q ? pole_rdata_q : '0;

  // Cascade input and band results.
  logic signed [POLE_W-1:0] x_q, l_q, hp_q, x_in, x_smp;
  logic signed [32:0]       diff;
  logic signed [33:0]       d3, l34, hp34, h34, m34;

  assign x_in  = {{7{in_sample_i[SMP_W-1]}}, in_sample_i, 1'b0};
  assign x_smp = {{7{smp_q[SMP_W-1]}}, smp_q, 1'b0};
  assign diff  = {x_q[POLE_W-1], x_q} - {p_cur[POLE_W-1], p_cur};

  assign d3   = {{9{hist_eff[SMP_W-1]}}, hist_eff, 1'b0};
  assign l34  = {{2{l_q[POLE_W-1]}}, l_q};
  assign hp34 = {{2{hp_q[POLE_W-1]}}, hp_q};
  assign h34  = d3 - hp34;
  assign m34  = hp34 - l34;

  // Shared multiplier.
  logic signed [33:0] mul_a;
  logic signed [20:0] mul_b;
  logic signed [54:0] prod_d, prod_q;

  always_comb begin
    mul_a = {diff[32], diff};
    mul_b = $signed({4'b0, cmd_i.op_idx[SEC_IDX_W-1] ? high_coef_q : low_coef_q});
    if (cmd_i.mul_gain) begin
      case (cmd_i.gsel)
        GAIN_LOW: begin
          mul_a = l34;
          mul_b = $signed({1'b0, low_gain_q});
        end
        GAIN_MID: begin
          mul_a = m34;
          mul_b = $signed({1'b0, mid_gain_q});
        end
        GAIN_HIGH: begin
          mul_a = h34;
          mul_b = $signed({1'b0, high_gain_q});
        end
        default: begin
          mul_a = '0;
          mul_b = '0;
        end
      endcase
    end
  end

  assign prod_d = mul_a * mul_b;

  // Pole update: round the product half up to Q8.24 and saturate the new pole.
  logic signed [54:0] upd, psum;
  assign upd  = (prod_q + 55'sd32768) >>> 16;
  assign psum = {{23{p_q[POLE_W-1]}}, p_q} + upd;

  always_comb begin
    if ((&psum[54:31]) || !(|psum[54:31])) begin
      new_pole = psum[31:0];
    end else if (psum[54]) begin
      new_pole = {1'b1, {(POLE_W-1){1'b0}}};
    end else begin
      new_pole = {1'b0, {(POLE_W-1){1'b1}}};
    end
  end

  // Accumulator and output rounding.
  logic signed [56:0]       acc_q, rsum;
  logic signed [SMP_W-1:0]  y_sat;

  assign rsum = (acc_q + 57'sd65536) >>> 17;

  always_comb begin
    if ((&rsum[56:23]) || !(|rsum[56:23])) begin
      y_sat = rsum[SMP_W-1:0];
    end else if (rsum[56]) begin
      y_sat = {1'b1, {(SMP_W-1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(SMP_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_pole) begin
      p_q    <= p_cur;
      prod_q <= prod_d;
    end else if (cmd_i.mul_gain) begin
      prod_q <= prod_d;
    end
    if (cmd_i.load) begin
      x_q <= x_in;
    end else if (cmd_i.upd_pole) begin
      // The high cascade restarts from the input sample.
      x_q <= (cmd_i.op_idx == LOW_LAST_SEC) ? x_smp : new_pole;
      if (cmd_i.op_idx == LOW_LAST_SEC)  l_q  <= new_pole;
      if (cmd_i.op_idx == HIGH_LAST_SEC) hp_q <= new_pole;
    end
    if (cmd_i.acc_first) begin
      acc_q <= 57'(prod_q);
    end else if (cmd_i.acc_add) begin
      acc_q <= acc_q + 57'(prod_q);
    end
    if (cmd_i.out_load) begin
      out_channel_o <= ch_q;
      out_sample_o  <= bypass_q ? smp_q : y_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  assign stat_o.bypass   = bypass_q;
  assign stat_o.out_free = !out_valid_o || out_ready_i;

  a_no_pole_on_bypass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.upd_pole |-> !bypass_q)
    else $error("pole written for a channel out of range");

  a_out_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |=> out_valid_o)
    else $error("output word not presented after load");

  a_hist_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.hist_wr |=> hist_vld_q[$past(hist_addr_q)])
    else $error("history entry not marked valid after write");

endmodule

/* rtl/core/three_band_equalizer_unit.sv */
// Three-band equalizer top level: sequencer, datapath and the channel interfaces.
// An accepted word steps through its poles, gains and output load; the next word is taken
// after that load, which waits while the output is held. A channel at or beyond CHANNELS
// skips poles and gains. All steps share the single multiplier: eight pole updates, each
// a multiply and an update step, three gain products and the accumulate and round steps.
// Reset clears all filter poles and input history through valid bits at once, and loads
// the 800 Hz / 5000 Hz coefficients and unity gains; no clearing pass is needed.
module three_band_equalizer_unit #(
  parameter int CHANNELS = teq_pkg::CHANNELS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  teq_in_if.sink                         in_i,
  teq_out_if.source                      out_o,
  input  logic                           cfg_we_i,
  input  logic [teq_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [teq_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import teq_pkg::*;

  teq_cmd_t  cmd;
  teq_stat_t stat;

  teq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  teq_dpath #(
    .CHANNELS (CHANNELS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .in_channel_i  (in_i.channel),
    .in_sample_i   (in_i.sample_in),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .out_channel_o (out_o.channel_out),
    .out_sample_o  (out_o.sample_out)
  );

endmodule

/* verif/tb_top.sv */
// Self-checking testbench of the three-band equalizer: directed table, random phases, scoreboard.
`timescale 1ns / 100ps

module tb_top;
  import teq_pkg::*;

  localparam int PHASES      = 6;
  localparam int PHASE_WORDS = 100;
  localparam int BANK_LOW    = 0;
  localparam int BANK_HIGH   = 1;

  localparam logic signed [SMP_W-1:0] SMP_MAX  = 24'sh7FFFFF;
  localparam logic signed [SMP_W-1:0] SMP_MIN  = 24'sh800000;
  localparam logic signed [SMP_W-1:0] SMP_ZERO = 24'sd0;
  localparam logic signed [SMP_W-1:0] SMP_NEG1 = -24'sd1;

  localparam logic [CFG_DATA_W-1:0] COEF_FULL = 20'h1FFFF;
  localparam logic [CFG_DATA_W-1:0] GAIN_FULL = 20'hFFFFF;
  localparam logic [CFG_DATA_W-1:0] GAIN_QTR  = 20'h04000;

  // Indexes past the register list; writes there must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = REG_HIGH_GAIN + 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam longint POLE_MAX = 64'sd2147483647;
  localparam longint POLE_MIN = -64'sd2147483648;
  localparam longint OUT_MAX  = 64'sd8388607;
  localparam longint OUT_MIN  = -64'sd8388608;

  typedef enum logic {ROW_WORD, ROW_REG} row_kind_e;

  typedef struct packed {
    row_kind_e               kind;
    logic [CFG_IDX_W-1:0]    idx;
    logic [CFG_DATA_W-1:0]   data;
    logic [CH_W-1:0]         ch;
    logic signed [SMP_W-1:0] smp;
    logic                    has_exp;
    logic signed [SMP_W-1:0] exp_smp;
  } eq_row_t;

  typedef struct {
    logic [CH_W-1:0]         ch;
    logic signed [SMP_W-1:0] smp;
  } eq_word_t;

  // With equal gains the three bands add back to the input delayed by three words,
  // so those rows carry their expected sample; the rest go through the predictor.
  localparam int DIR_ROWS = 38;
  localparam eq_row_t DIRECTED [DIR_ROWS] = '{
    '{ROW_WORD, '0, '0, 3'd0, SMP_ZERO,      1'b1, SMP_ZERO},
    '{ROW_WORD, '0, '0, 3'd0, SMP_MAX,       1'b1, SMP_ZERO},
    '{ROW_WORD, '0, '0, 3'd0, SMP_MIN,       1'b1, SMP_ZERO},
    '{ROW_WORD, '0, '0, 3'd0, SMP_NEG1,      1'b1, SMP_ZERO},
    '{ROW_WORD, '0, '0, 3'd0, SMP_ZERO,      1'b1, SMP_MAX},
    '{ROW_WORD, '0, '0, 3'd0, SMP_ZERO,      1'b1, SMP_MIN},
    '{ROW_WORD, '0, '0, 3'd0, SMP_ZERO,      1'b1, SMP_NEG1},
    '{ROW_WORD, '0, '0, 3'd7, 24'sh555555,   1'b0, SMP_ZERO},
    '{ROW_WORD, '0, '0, 3'd7, 24'shAAAAAA,   1'b0, SMP_ZERO},
    '{ROW_REG,  REG_LOW_GAIN,  GAIN_FULL, '0, SMP_ZERO, 1'b0, SMP_ZERO},
    '{ROW_REG,  REG_MID_GAIN,  GAIN_FULL, '0, SMP_ZERO, 1'b0, SMP_ZERO},
    '{ROW_REG,  REG_HIGH_GAIN, GAIN_FULL, '0, SMP_ZERO, 1'b0, SMP_ZERO},
    '{ROW_REG,  REG_SPARE_HI,  '0,        '0, SMP_ZERO, 1'b0, SMP_ZERO},
    '{ROW_WORD, '0, '0, 3'd0, SMP_MAX,       1'b1, SMP_ZERO},
    '{ROW_WORD, '0, '0, 3'd0, SMP_MIN,       1'b1, SMP_ZERO},
    '{ROW_WORD, '0, '0, 3'd0, SMP_ZERO,      1'b1, SMP_ZERO},
    '{ROW_WORD, '0, '0, 3'd0, SMP_ZERO,      1'b1, SMP_MAX},
    '{ROW_WORD, '0, '0, 3'd0, SMP_ZERO,      1'b1, SMP_MIN},
    '{ROW_REG,  REG_LOW_GAIN,  '0,        '0, SMP_ZERO, 1'b0, SMP_ZERO},
    '{ROW_REG,  REG_MID_GAIN,  '0,        '0, SMP_ZERO, 1'b0, SMP_ZERO},
    '{ROW_REG,  REG_HIGH_GAIN, '0,        '0, SMP_ZERO, 1'b0, SMP_ZERO},
    '{ROW_WORD, '0, '0, 3'd3, SMP_MAX,       1'b1, SMP_ZERO},
    '{ROW_WORD, '0, '0, 3'd3, SMP_MIN,       1'b1, SMP_ZERO},
    '{ROW_REG,  REG_LOW_COEF,  COEF_FULL, '0, SMP_ZERO, 1'b0, SMP_ZERO},
    '{ROW_REG,  REG_HIGH_COEF, '0,        '0, SMP_ZERO, 1'b0, SMP_ZERO},
    '{ROW_REG,  REG_LOW_GAIN,  GAIN_RST,  '0, SMP_ZERO, 1'b0, SMP_ZERO},
    '{ROW_REG,  REG_MID_GAIN,  GAIN_QTR,  '0, SMP_ZERO, 1'b0, SMP_ZERO},
    '{ROW_REG,  REG_HIGH_GAIN, GAIN_FULL, '0, SMP_ZERO, 1'b0, SMP_ZERO},
    '{ROW_WORD, '0, '0, 3'd2, SMP_MAX,       1'b0, SMP_ZERO},
    '{ROW_WORD, '0, '0, 3'd2, SMP_MIN,       1'b0, SMP_ZERO},
    '{ROW_WORD, '0, '0, 3'd2, SMP_MAX,       1'b0, SMP_ZERO},
    '{ROW_WORD, '0, '0, 3'd2, SMP_MIN,       1'b0, SMP_ZERO},
    '{ROW_WORD, '0, '0, 3'd2, SMP_MAX,       1'b0, SMP_ZERO},
    '{ROW_REG,  REG_LOW_COEF,  '0,        '0, SMP_ZERO, 1'b0, SMP_ZERO},
    '{ROW_REG,  REG_HIGH_COEF, COEF_FULL, '0, SMP_ZERO, 1'b0, SMP_ZERO},
    '{ROW_WORD, '0, '0, 3'd5, SMP_MIN,       1'b0, SMP_ZERO},
    '{ROW_WORD, '0, '0, 3'd5, SMP_MAX,       1'b0, SMP_ZERO},
    '{ROW_WORD, '0, '0, 3'd5, 24'sd1,        1'b0, SMP_ZERO}
  };

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  teq_in_if  in_if ();
  teq_out_if out_if ();

  three_band_equalizer_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state: both pole cascades per channel, input delay line, registers.
  logic signed [POLE_W-1:0] pole_q [2][CHANNELS_DEF][4];
  logic signed [SMP_W-1:0]  hist_q [CHANNELS_DEF][3];
  logic [COEF_W-1:0]        coef_q [2];
  logic [GAIN_W-1:0]        gain_q [3];

  eq_word_t pending_words [$];
  int       miss_count;
  logic     src_idle;
  logic     sink_idle;
  logic [1:0] stall_left;
  int       walk_lvl [CHANNELS_DEF];

  function automatic longint run_chain(input int bank, input int ch, input longint coef,
                                       input longint x);
    longint feed, cur, nxt;
    feed = x;
    for (int k = 0; k < 4; k++) begin
      cur = pole_q[bank][ch][k];
      nxt = cur + ((coef * (feed - cur) + 64'sd32768) >>> 16);
      if (nxt > POLE_MAX) nxt = POLE_MAX;
      else if (nxt < POLE_MIN) nxt = POLE_MIN;
      pole_q[bank][ch][k] = nxt[POLE_W-1:0];
      feed = nxt;
    end
    return feed;
  endfunction

  function automatic logic signed [SMP_W-1:0] equalize(input logic [CH_W-1:0] ch,
                                                       input logic signed [SMP_W-1:0] smp);
    longint x, lo, hp, d3, hi, mid, acc, y;
    if (int'(ch) >= CHANNELS_DEF) return smp;
    x   = longint'(smp) * 2;
    lo  = run_chain(BANK_LOW, int'(ch), longint'(coef_q[BANK_LOW]), x);
    hp  = run_chain(BANK_HIGH, int'(ch), longint'(coef_q[BANK_HIGH]), x);
    d3  = longint'(hist_q[ch][2]) * 2;
    hi  = d3 - hp;
    mid = d3 - (hi + lo);
    acc = lo * longint'(gain_q[GAIN_LOW]) + mid * longint'(gain_q[GAIN_MID])
        + hi * longint'(gain_q[GAIN_HIGH]);
    y = (acc + 64'sd65536) >>> 17;
    if (y > OUT_MAX) y = OUT_MAX;
    else if (y < OUT_MIN) y = OUT_MIN;
    hist_q[ch][2] = hist_q[ch][1];
    hist_q[ch][1] = hist_q[ch][0];
    hist_q[ch][0] = smp;
    return y[SMP_W-1:0];
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_coef();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return COEF_FULL;
      2: return CFG_DATA_W'($urandom_range(0, COEF_FULL));
      default: return CFG_DATA_W'($urandom_range(0, 20'h07FFF));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_gain();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return GAIN_FULL;
      2: return CFG_DATA_W'($urandom_range(0, GAIN_FULL));
      default: return CFG_DATA_W'($urandom_range(0, 20'h3FFFF));
    endcase
  endfunction

  task automatic log_miss(input string what, input longint want_v, input longint got_v);
    miss_count++;
    if (miss_count <= 10)
      $display("mismatch on %s: expected %0d, got %0d at %0t", what, want_v, got_v, $realtime);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      REG_LOW_COEF:  coef_q[BANK_LOW]  = data[COEF_W-1:0];
      REG_HIGH_COEF: coef_q[BANK_HIGH] = data[COEF_W-1:0];
      REG_LOW_GAIN:  gain_q[GAIN_LOW]  = data;
      REG_MID_GAIN:  gain_q[GAIN_MID]  = data;
      REG_HIGH_GAIN: gain_q[GAIN_HIGH] = data;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Valid is left high after a handshake unless a gap follows, so back-to-back words
  // never see a lower and a raise in the same step.
  task automatic send_word(input logic [CH_W-1:0] ch, input logic signed [SMP_W-1:0] smp,
                           input logic has_exp, input logic signed [SMP_W-1:0] exp_smp);
    eq_word_t    pred;
    int unsigned gap;
    cfg_we_i          <= 1'b0;
    in_if.valid       <= 1'b1;
    in_if.channel     <= ch;
    in_if.sample_in   <= smp;
    do @(posedge clk_i); while (!in_if.ready);
    pred.ch  = ch;
    pred.smp = equalize(ch, smp);
    if (has_exp) pred.smp = exp_smp;
    pending_words.push_back(pred);
    gap = src_idle ? $urandom_range(0, 3) : 0;
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    cfg_we_i    <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // Result side: a stall is drawn at each accepted word and spent once the next word waits.
  always @(posedge clk_i) begin : result_sink
    eq_word_t    want;
    int unsigned pause;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_left   <= '0;
    end else if (out_if.valid && out_if.ready) begin
      if (pending_words.size() == 0) begin
        log_miss("unexpected word", 64'sd0, longint'(out_if.sample_out));
      end else begin
        want = pending_words.pop_front();
        if (out_if.channel_out !== want.ch)
          log_miss("channel_out", longint'(want.ch), longint'(out_if.channel_out));
        if (out_if.sample_out !== want.smp)
          log_miss("sample_out", longint'(want.smp), longint'(out_if.sample_out));
      end
      pause = sink_idle ? $urandom_range(0, 3) : 0;
      stall_left   <= pause[1:0];
      out_if.ready <= (pause == 0);
    end else if (stall_left != 0) begin
      if (out_if.valid) begin
        stall_left <= stall_left - 2'd1;
        if (stall_left == 2'd1) out_if.ready <= 1'b1;
      end
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  initial begin : stimulus
    logic                    after_word;
    logic [CH_W-1:0]         ch;
    logic signed [SMP_W-1:0] smp;
    logic [31:0]             raw;
    logic [CFG_IDX_W-1:0]    spare;
    int                      lvl;

    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = '0;
    cfg_data_i      = '0;
    in_if.valid     = 1'b0;
    in_if.channel   = '0;
    in_if.sample_in = '0;
    src_idle        = 1'b1;
    sink_idle       = 1'b1;
    miss_count      = 0;
    coef_q[BANK_LOW]  = LOW_COEF_RST;
    coef_q[BANK_HIGH] = HIGH_COEF_RST;
    for (int g = 0; g < 3; g++) gain_q[g] = GAIN_RST;
    for (int c = 0; c < CHANNELS_DEF; c++) begin
      walk_lvl[c] = 0;
      for (int k = 0; k < 4; k++) begin
        pole_q[BANK_LOW][c][k]  = '0;
        pole_q[BANK_HIGH][c][k] = '0;
      end
      for (int k = 0; k < 3; k++) hist_q[c][k] = '0;
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    after_word = 1'b1;
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (DIRECTED[i].kind == ROW_REG) begin
        if (after_word) drain();
        write_reg(DIRECTED[i].idx, DIRECTED[i].data);
        after_word = 1'b0;
      end else begin
        send_word(DIRECTED[i].ch, DIRECTED[i].smp, DIRECTED[i].has_exp, DIRECTED[i].exp_smp);
        after_word = 1'b1;
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      if (ph == 0) begin
        write_reg(REG_LOW_COEF, LOW_COEF_RST);
        write_reg(REG_HIGH_COEF, HIGH_COEF_RST);
        write_reg(REG_LOW_GAIN, GAIN_RST);
        write_reg(REG_MID_GAIN, GAIN_RST);
        write_reg(REG_HIGH_GAIN, GAIN_RST);
      end else begin
        write_reg(REG_LOW_COEF, pick_coef());
        write_reg(REG_HIGH_COEF, pick_coef());
        write_reg(REG_LOW_GAIN, pick_gain());
        write_reg(REG_MID_GAIN, pick_gain());
        write_reg(REG_HIGH_GAIN, pick_gain());
        spare = CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI));
        write_reg(spare, pick_gain());
      end
      // One phase runs with both sides at full rate.
      src_idle  = (ph != 2);
      sink_idle = (ph != 2);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if ($urandom_range(0, 49) == 0) drain();
        ch = CH_W'($urandom_range(0, CHANNELS_DEF - 1));
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            raw = $urandom();
            smp = raw[SMP_W-1:0];
          end
          4, 5, 6: begin
            // Audio-like random walk per channel.
            lvl = walk_lvl[ch] + int'($urandom_range(0, 131072)) - 65536;
            if (lvl > 8388607) lvl = 8388607;
            else if (lvl < -8388608) lvl = -8388608;
            walk_lvl[ch] = lvl;
            smp = lvl[SMP_W-1:0];
          end
          7: begin
            lvl = int'($urandom_range(0, 2047)) - 1024;
            smp = lvl[SMP_W-1:0];
          end
          default: begin
            case ($urandom_range(0, 3))
              0: smp = SMP_MAX;
              1: smp = SMP_MIN;
              2: smp = SMP_ZERO;
              default: smp = SMP_NEG1;
            endcase
          end
        endcase
        send_word(ch, smp, 1'b0, SMP_ZERO);
      end
    end

    drain();
    repeat (30) @(posedge clk_i);
    if (miss_count == 0 && pending_words.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("timeout with %0d words outstanding", pending_words.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
